@@ rtl/processor_grid_factor_split_macros.svh @@
// ----------------------------------------------------------------------------
// processor_grid_factor_split_macros
// Assertion shorthands shared by the grid factor split modules.
// ----------------------------------------------------------------------------
`ifndef PROCESSOR_GRID_FACTOR_SPLIT_MACROS_SVH
`define PROCESSOR_GRID_FACTOR_SPLIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define PGFS_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define PGFS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pgfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pgfs_pkg
// Shared constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package pgfs_pkg;

  localparam int MAX_FACTORS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int FIELD_W         = 16;
  localparam int NDIM_W          = 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_DIST  = 6'b001000,
    S_SORT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic take_factor;
    logic next_p;
    logic put_n;
    logic dist_step;
    logic sort;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic n_gt1;
    logic psq_gt_n;
    logic div_done;
    logic rem_zero;
    logic dist_last;
  } status_t;

endpackage

@@ rtl/pgfs_div.sv @@
// ----------------------------------------------------------------------------
// pgfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgfs_div #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_diff;
  logic          ge;

  assign rem_sh   = {rem, quo[W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ rtl/pgfs_dp.sv @@
// ----------------------------------------------------------------------------
// pgfs_dp
// Datapath: factor list, trial divisor, slot products and final ranking.
// ----------------------------------------------------------------------------
`include "processor_grid_factor_split_macros.svh"

module pgfs_dp #(
  parameter int MF = 16,
  parameter int CB = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pgfs_pkg::cmd_t                         cmd,
  output pgfs_pkg::status_t                      st,
  input  logic [pgfs_pkg::FIELD_W-1:0]           nproc,
  input  logic [pgfs_pkg::NDIM_W-1:0]            ndim,
  input  logic [pgfs_pkg::FIELD_W-1:0]           res_x,
  input  logic [pgfs_pkg::FIELD_W-1:0]           res_y,
  input  logic [pgfs_pkg::FIELD_W-1:0]           res_z,
  output logic [pgfs_pkg::FIELD_W-1:0]           dis_x,
  output logic [pgfs_pkg::FIELD_W-1:0]           dis_y,
  output logic [pgfs_pkg::FIELD_W-1:0]           dis_z
);

  import pgfs_pkg::*;

  localparam int IW = $clog2(MF);
  localparam int FW = $clog2(MF + 1);
  localparam int PW = CB + 2;

  function automatic logic [FIELD_W-1:0] to_field(input logic [CB-1:0] v);
    logic [CB+FIELD_W-1:0] e;
    e = {{FIELD_W{1'b0}}, v};
    return e[FIELD_W-1:0];
  endfunction

  logic [CB-1:0]      n;
  logic [CB-1:0]      p;
  logic [PW-1:0]      psq;
  logic [CB-1:0]      fac [MF];
  logic [FW-1:0]      nfact;
  logic [1:0]         act;
  logic               dim3;
  logic               trivial;
  logic [FIELD_W-1:0] res [3];
  logic [CB-1:0]      dis [3];
  logic [FW-1:0]      k;
  logic [1:0]         j;

  logic                  div_done;
  logic [CB-1:0]         quo;
  logic [CB-1:0]         rem;

  // Load-side decode.
  logic [CB+FIELD_W-1:0] n_ext;
  logic [CB-1:0]         n_in;
  logic                  dim3_in;
  logic [1:0]            act_in;

  assign n_ext   = {{CB{1'b0}}, nproc};
  assign n_in    = n_ext[CB-1:0];
  assign dim3_in = ndim == 2'b11;

  always_comb begin
    act_in = 2'd0;
    if (res_x != FIELD_W'(1)) act_in = act_in + 2'd1;
    if (res_y != FIELD_W'(1)) act_in = act_in + 2'd1;
    if (dim3_in && res_z != FIELD_W'(1)) act_in = act_in + 2'd1;
  end

  // Factor insertion; a full list folds the factor into its last entry.
  logic [CB-1:0]   fval;
  logic [2*CB-1:0] fold;
  logic            full;

  assign fval = cmd.put_n ? n : p;
  assign fold = fac[MF-1] * fval;
  assign full = nfact == FW'(MF);

  // Slot selection while spreading factors.
  logic [FW-1:0]   act_w;
  logic [FW-1:0]   surplus;
  logic [FW-1:0]   tail_off;
  logic [1:0]      slot;
  logic            use_rr;
  logic [CB-1:0]   fac_k;
  logic [2*CB-1:0] dmul;

  assign act_w    = FW'(act);
  assign surplus  = nfact - act_w;
  assign tail_off = k - surplus;
  assign fac_k    = fac[k[IW-1:0]];

  always_comb begin
    use_rr = 1'b0;
    if (act_w >= nfact) begin
      slot = k[1:0];
    end else if (k >= surplus) begin
      slot = tail_off[1:0];
    end else begin
      slot   = j;
      use_rr = 1'b1;
    end
  end

  assign dmul = dis[slot] * fac_k;

  // Stable ranks of resolutions and of slot counts; smallest to smallest.
  logic [1:0]    rr [3];
  logic [1:0]    rd [3];
  logic [CB-1:0] sv [3];
  logic [2:0]    a;

  assign a = {dim3, 2'b11};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[i] = 2'd0;
      rd[i] = 2'd0;
      for (int m = 0; m < 3; m++) begin
        if (m != i && a[m] && a[i]) begin
          if (res[m] < res[i] || (res[m] == res[i] && m < i)) rr[i] = rr[i] + 2'd1;
          if (dis[m] < dis[i] || (dis[m] == dis[i] && m < i)) rd[i] = rd[i] + 2'd1;
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      sv[i] = CB'(1);
      for (int m = 0; m < 3; m++) begin
        if (a[m] && a[i] && rd[m] == rr[i]) sv[i] = dis[m];
      end
    end
  end

  pgfs_div #(.W(CB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (n),
    .divisor   (p),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nfact <= '0;
      k     <= '0;
      j     <= 2'd0;
    end else if (cmd.load) begin
      nfact <= '0;
      k     <= '0;
      j     <= 2'd0;
    end else begin
      if ((cmd.take_factor || cmd.put_n) && !full) nfact <= nfact + FW'(1);
      if (cmd.dist_step) begin
        k <= k + FW'(1);
        if (use_rr) j <= (j + 2'd1 == act) ? 2'd0 : j + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= n_in;
      p       <= CB'(2);
      psq     <= PW'(4);
      act     <= act_in;
      dim3    <= dim3_in;
      trivial <= (n_in <= CB'(1)) || (act_in == 2'd0);
      res[0]  <= res_x;
      res[1]  <= res_y;
      res[2]  <= dim3_in ? res_z : FIELD_W'(1);
      for (int i = 0; i < 3; i++) dis[i] <= CB'(1);
    end else begin
      if (cmd.take_factor || cmd.put_n) begin
        if (full) fac[MF-1] <= fold[CB-1:0];
        else      fac[nfact[IW-1:0]] <= fval;
      end
      if (cmd.take_factor) n <= quo;
      if (cmd.put_n)       n <= CB'(1);
      if (cmd.next_p) begin
        p   <= p + CB'(1);
        psq <= psq + PW'({p, 1'b1});
      end
      if (cmd.dist_step) dis[slot] <= dmul[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort) begin
      dis_x <= to_field(sv[0]);
      dis_y <= to_field(sv[1]);
      dis_z <= dim3 ? to_field(sv[2]) : FIELD_W'(1);
    end
  end

  assign st.trivial   = trivial;
  assign st.n_gt1     = n > CB'(1);
  assign st.psq_gt_n  = psq > PW'(n);
  assign st.div_done  = div_done;
  assign st.rem_zero  = rem == '0;
  assign st.dist_last = k + FW'(1) == nfact;

  `PGFS_ASSERT_IMPLY(a_dist_in_list, clk, rst, cmd.dist_step, k < nfact, "spread past factor list")
  `PGFS_ASSERT_IMPLY(a_nfact_bound, clk, rst, 1'b1, nfact <= FW'(MF), "factor count overflow")

endmodule

@@ rtl/pgfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// pgfs_ctrl
// Controller: sequences load, trial division, spreading, ranking, output.
// ----------------------------------------------------------------------------
`include "processor_grid_factor_split_macros.svh"

module pgfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pgfs_pkg::status_t st,
  output pgfs_pkg::cmd_t    cmd
);

  import pgfs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.trivial) begin
          state_next = S_SORT;
        end else if (!st.n_gt1) begin
          state_next = S_DIST;
        end else if (st.psq_gt_n) begin
          cmd.put_n  = 1'b1;
          state_next = S_DIST;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          if (st.rem_zero) cmd.take_factor = 1'b1;
          else             cmd.next_p      = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_DIST: begin
        cmd.dist_step = 1'b1;
        if (st.dist_last) state_next = S_SORT;
      end
      S_SORT: begin
        cmd.sort   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_OUT;

  `PGFS_ASSERT_NEXT(a_div_wait, clk, rst, cmd.div_start, state == S_DIV, "divide not awaited")
  `PGFS_ASSERT_IMPLY(a_done_in_div, clk, rst, st.div_done, state == S_DIV, "stray divide done")
  `PGFS_ASSERT_NEXT(a_sort_shows, clk, rst, cmd.sort, out_valid, "ranked result not shown")

endmodule

@@ rtl/processor_grid_factor_split.sv @@
// ----------------------------------------------------------------------------
// processor_grid_factor_split
// Splits a processor count over a 2- or 3-axis grid by prime factors.
// ----------------------------------------------------------------------------
// One request in, one beat out. The count is factored by trial division on a
// single bit-serial divider. Trials run up to the larger of the second-largest
// prime factor and the square root of the largest. Trivial requests (count
// below two or no unfrozen axis) go straight from the check to ranking. One
// request is in flight at a time: in_stall stays high from acceptance until the
// result beat is taken. Axes with resolution 1 are frozen; ndim values other
// than 3 mean two axes and dis_z then reads 1.
// ----------------------------------------------------------------------------
module processor_grid_factor_split #(
  parameter int MAX_FACTORS = pgfs_pkg::MAX_FACTORS_DEF,
  parameter int COUNT_BITS  = pgfs_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pgfs_pkg::FIELD_W-1:0] nproc,
  input  logic [pgfs_pkg::NDIM_W-1:0]  ndim,
  input  logic [pgfs_pkg::FIELD_W-1:0] res_x,
  input  logic [pgfs_pkg::FIELD_W-1:0] res_y,
  input  logic [pgfs_pkg::FIELD_W-1:0] res_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pgfs_pkg::FIELD_W-1:0] dis_x,
  output logic [pgfs_pkg::FIELD_W-1:0] dis_y,
  output logic [pgfs_pkg::FIELD_W-1:0] dis_z
);

  import pgfs_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequence the request: load, factor, spread over slots, rank, hold beat.
  pgfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Hold operands, factor list and slot products; drive the result beat.
  pgfs_dp #(
    .MF (MAX_FACTORS),
    .CB (COUNT_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .st    (st),
    .nproc (nproc),
    .ndim  (ndim),
    .res_x (res_x),
    .res_y (res_y),
    .res_z (res_z),
    .dis_x (dis_x),
    .dis_y (dis_y),
    .dis_z (dis_z)
  );

endmodule
